### rtl/periodic_timer_slot_table_macros.svh
// Assertion macros shared by the checker of the periodic timer slot table.
// Depends on nothing; expects signals clk and arst_n in the including scope.
`ifndef PERIODIC_TIMER_SLOT_TABLE_MACROS_SVH
`define PERIODIC_TIMER_SLOT_TABLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTST_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("periodic timer slot table: check failed");

// Consequent must hold in the cycle after the antecedent.
`define PTST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("periodic timer slot table: check failed");

`endif

### rtl/ptst_pkg.sv
// Package for the periodic timer slot table: widths, command and result codes,
// and the result type of the shared slot unit. Depends on nothing.
package ptst_pkg;

	localparam int SLOTS_DEF  = 8;
	localparam int CNT_W      = 16;
	localparam int CMD_W      = 2;
	localparam int KIND_W     = 2;
	localparam int SLOT_W     = 6;
	localparam int ID_W       = 8;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 8;

	localparam logic [CNT_W-1:0] COUNT_TOP = {CNT_W{1'b1}};

	localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;

	localparam logic [KIND_W-1:0] KIND_REGISTERED = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FULL       = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REMOVE     = 2'd2;
	localparam logic [KIND_W-1:0] KIND_FIRED      = 2'd3;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             due;
	} slot_eval_t;

endpackage

### rtl/ptst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module ptst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/ptst_slot_unit.sv
// Shared slot unit: saturating count increment and compare against the period.
// Depends on ptst_pkg.
module ptst_slot_unit (
	input  logic [ptst_pkg::CNT_W-1:0] count,
	input  logic [ptst_pkg::CNT_W-1:0] period,
	output ptst_pkg::slot_eval_t       eval
);
	import ptst_pkg::*;

	logic [CNT_W-1:0] count_inc;

	// hold at the top instead of wrapping
	assign count_inc  = (count == COUNT_TOP) ? count : count + 1'b1;
	assign eval.count = count_inc;
	assign eval.due   = (count_inc >= period);

endmodule

### rtl/periodic_timer_slot_table.sv
// Top level of the periodic timer slot table: sequencer, valid bits, output register.
// Depends on ptst_pkg, ptst_ram and ptst_slot_unit.
//
// A table of SLOTS periodic timer slots driven by request streams. A register
// request (command 0) claims the lowest free slot from 1 upward, stores its
// period, clears its count and answers with kind 0 and the slot, or kind 1 with
// slot 0 when slots 1 to SLOTS-1 are all taken. A remove request (command 1)
// frees slot_id if it is below SLOTS and always answers kind 2 with slot 0.
// A tick request (command 2) adds one to every live count, saturating at 65535,
// and answers kind 3 once for each valid slot whose count has reached its
// period, in ascending slot order, clearing that count; a tick with no due
// slot answers nothing, and command 3 is dropped silently. The final answer of
// each request carries tlast. A register or remove request occupies the block
// for its accept and command step; a tick request occupies it for its accept,
// command step, a scan of one slot per cycle unless stalled, and flush, because
// periods and counts live in one RAM with a single read port and every slot
// passes through one shared increment/compare unit. Backpressure on the result
// stream holds a register or remove request in its command step while the
// output register is full, stretches a tick when a second due slot finds the
// output register still full, and holds the final fire of a tick until the
// output register frees. The block takes the next request while an earlier
// result waits in the output register. No clearing pass is needed after reset:
// the entry of a slot is only used once a register request wrote it.
module periodic_timer_slot_table #(
	parameter int SLOTS = ptst_pkg::SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [ptst_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // period[15:0], slot_id[23:16]
	input  logic [ptst_pkg::CMD_W-1:0]      s_axis_tuser,  // command[1:0]
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [ptst_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // slot[5:0], zero[7:6]
	output logic [ptst_pkg::KIND_W-1:0]     m_axis_tuser,  // kind[1:0]
	output logic                            m_axis_tlast
);
	import ptst_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int RW = 2 * CNT_W;
	localparam logic [ID_W:0]   SLOTS_V  = (ID_W + 1)'(SLOTS);
	localparam logic [IW-1:0]   LAST_IDX = IW'(SLOTS - 1);

	// sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;  // wait for a request
	localparam logic [1:0] ST_CMD   = 2'd1;  // act on a register, remove or tick
	localparam logic [1:0] ST_SCAN  = 2'd2;  // one slot per cycle through the unit unless stalled
	localparam logic [1:0] ST_FLUSH = 2'd3;  // release the held fire with tlast

	logic [1:0]       state_q;
	logic [SLOTS-1:0] slot_valid_q;
	logic [IW-1:0]    idx_q;

	// latched request
	logic [CMD_W-1:0] cmd_q;
	logic [CNT_W-1:0] period_q;
	logic [ID_W-1:0]  slot_id_q;

	// a fire is held back until the next fire or the flush so the final one can carry tlast
	logic             pend_q;
	logic [IW-1:0]    pend_slot_q;

	// output register
	logic                  m_valid_q;
	logic [SLOT_W-1:0]     m_slot_q;
	logic [KIND_W-1:0]     m_kind_q;
	logic                  m_last_q;

	// RAM holds {period, count} per slot
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [RW-1:0] ram_wdata;
	logic [IW-1:0] ram_raddr;
	logic [RW-1:0] ram_rdata;

	logic [CNT_W-1:0] rd_period;
	logic [CNT_W-1:0] rd_count;
	slot_eval_t       eval;

	logic          can_push;
	logic          free_ok;
	logic [IW-1:0] free_idx;
	logic          rm_ok;
	logic          fire;
	logic          stall;
	logic          adv;
	logic          last_slot;

	logic              push;
	logic [KIND_W-1:0] push_kind;
	logic [SLOT_W-1:0] push_slot;
	logic              push_last;

	ptst_ram #(
		.WIDTH(RW),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_period = ram_rdata[RW-1:CNT_W];
	assign rd_count  = ram_rdata[CNT_W-1:0];

	ptst_slot_unit u_unit (
		.count (rd_count),
		.period(rd_period),
		.eval  (eval)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign can_push      = !m_valid_q || m_axis_tready;

	// lowest free slot from 1 upward; slot 0 is never claimed
	always_comb begin
		free_ok  = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 1; i--) begin
			if (!slot_valid_q[i]) begin
				free_ok  = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	assign rm_ok = ({1'b0, slot_id_q} < SLOTS_V);

	// scan step: an invalid slot never fires and its count is never looked at
	assign last_slot = (idx_q == LAST_IDX);
	assign fire      = slot_valid_q[idx_q] && eval.due;
	assign stall     = fire && pend_q && !can_push;
	assign adv       = (state_q == ST_SCAN) && !stall;

	// read one slot ahead while advancing, hold the address on a stall
	assign ram_raddr = (adv && !last_slot) ? idx_q + 1'b1 : idx_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = {rd_period, (fire ? {CNT_W{1'b0}} : eval.count)};
		if (state_q == ST_CMD && cmd_q == CMD_REGISTER && can_push && free_ok) begin
			ram_we    = 1'b1;
			ram_waddr = free_idx;
			ram_wdata = {period_q, {CNT_W{1'b0}}};
		end else if (adv && slot_valid_q[idx_q]) begin
			ram_we = 1'b1;
		end
	end

	// result selection
	always_comb begin
		push      = 1'b0;
		push_kind = KIND_FIRED;
		push_slot = SLOT_W'(pend_slot_q);
		push_last = 1'b0;
		case (state_q)
			ST_CMD: begin
				if (can_push && cmd_q == CMD_REGISTER) begin
					push      = 1'b1;
					push_kind = free_ok ? KIND_REGISTERED : KIND_FULL;
					push_slot = free_ok ? SLOT_W'(free_idx) : '0;
					push_last = 1'b1;
				end else if (can_push && cmd_q == CMD_REMOVE) begin
					push      = 1'b1;
					push_kind = KIND_REMOVE;
					push_slot = '0;
					push_last = 1'b1;
				end
			end
			ST_SCAN: begin
				// a new fire releases the one held before it
				push = adv && fire && pend_q;
			end
			ST_FLUSH: begin
				push      = pend_q && can_push;
				push_last = 1'b1;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// sequencer and slot valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			slot_valid_q <= '0;
			idx_q        <= '0;
			pend_q       <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= ST_CMD;
					end
				end
				ST_CMD: begin
					case (cmd_q)
						CMD_REGISTER: begin
							if (can_push) begin
								if (free_ok) begin
									slot_valid_q[free_idx] <= 1'b1;
								end
								state_q <= ST_IDLE;
							end
						end
						CMD_REMOVE: begin
							if (can_push) begin
								if (rm_ok) begin
									slot_valid_q[slot_id_q[IW-1:0]] <= 1'b0;
								end
								state_q <= ST_IDLE;
							end
						end
						CMD_TICK: begin
							state_q <= ST_SCAN;
						end
						default: begin
							// unused command: drop
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_SCAN: begin
					if (adv) begin
						if (fire) begin
							pend_q <= 1'b1;
						end
						if (last_slot) begin
							idx_q   <= '0;
							state_q <= ST_FLUSH;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_q) begin
						state_q <= ST_IDLE;
					end else if (can_push) begin
						pend_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request and held-fire payload
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_q     <= s_axis_tuser;
			period_q  <= s_axis_tdata[CNT_W-1:0];
			slot_id_q <= s_axis_tdata[CNT_W+ID_W-1:CNT_W];
		end
		if (adv && fire) begin
			pend_slot_q <= idx_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (push) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			m_kind_q <= push_kind;
			m_slot_q <= push_slot;
			m_last_q <= push_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - SLOT_W){1'b0}}, m_slot_q};
	assign m_axis_tuser  = m_kind_q;
	assign m_axis_tlast  = m_last_q;

endmodule

### rtl/ptst_checker.sv
// Port-level checker for the periodic timer slot table, bound to the top level.
// Depends on ptst_pkg and periodic_timer_slot_table_macros.svh.
`include "periodic_timer_slot_table_macros.svh"

module ptst_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [ptst_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [ptst_pkg::KIND_W-1:0]     m_axis_tuser,
	input logic                            m_axis_tlast
);
	import ptst_pkg::*;

	// a stalled result holds
	`PTST_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// one request at a time: busy right after an accept
	`PTST_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// register, full and remove answers are single and final
	`PTST_ASSERT_NOW(a_single_last, m_axis_tvalid && m_axis_tuser != KIND_FIRED, m_axis_tlast)

	// full and remove answers carry slot zero
	`PTST_ASSERT_NOW(a_zero_slot, m_axis_tvalid && (m_axis_tuser == KIND_FULL || m_axis_tuser == KIND_REMOVE), m_axis_tdata == '0)

	// slot zero is never claimed
	`PTST_ASSERT_NOW(a_reg_nonzero, m_axis_tvalid && m_axis_tuser == KIND_REGISTERED, m_axis_tdata != '0)

endmodule

bind periodic_timer_slot_table ptst_checker u_ptst_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);
